### rtl/core/ccpc_pkg.sv
// Package for the convolutional code property check: item types, the queued
// job format, sizes and the branch weight helper. No dependencies.
`timescale 1ns / 1ps
package ccpc_pkg;

    localparam int MaxConstraint = 9;
    localparam int MaxGenerators = 5;
    localparam int GenW          = MaxConstraint;
    localparam int StW           = MaxConstraint - 1;
    localparam int States        = 1 << StW;
    localparam int WtW           = 7;
    localparam int GrpSize       = 16;
    localparam int Groups        = States / GrpSize;

    localparam logic [3:0] K_MIN = 4'd3;
    localparam logic [3:0] K_MAX = 4'd9;
    localparam logic [2:0] N_MIN = 3'd2;
    localparam logic [2:0] N_MAX = 3'd5;
    localparam logic [3:0] K_RESET = 4'd7;
    localparam logic [2:0] N_RESET = 3'd2;

    localparam logic [1:0] CFG_CONSTRAINT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_GENERATOR_COUNT   = 2'd1;

    typedef struct packed {
        logic [8:0] gen_0;
        logic [8:0] gen_1;
        logic [8:0] gen_2;
        logic [8:0] gen_3;
        logic [8:0] gen_4;
    } t_in_item;

    typedef struct packed {
        logic       noncatastrophic;
        logic [5:0] free_dist;
    } t_out_item;

    typedef logic [MaxGenerators-1:0][GenW-1:0] t_gens;

    typedef struct packed {
        t_gens      gens;
        logic [3:0] k;
        logic [2:0] n;
        logic       nc;
    } t_job;

    // Number of ones among the active generators over the register
    // (bit << (k-1)) | st.
    function automatic logic [2:0] out_ones(input t_gens gens, input logic [2:0] n,
                                            input logic [3:0] k,
                                            input logic [StW-1:0] st,
                                            input logic bit_in);
        logic [GenW-1:0] sr;
        logic [2:0]      w;
        sr = (GenW'(bit_in) << (k - 4'd1)) | {1'b0, st};
        w  = '0;
        for (int j = 0; j < MaxGenerators; j++) begin
            if (3'(j) < n) begin
                w = w + 3'(^(sr & gens[j]));
            end
        end
        return w;
    endfunction

endpackage

### rtl/core/conv_code_property_check_unit.sv
// Convolutional code property check, top level: front classifier, job queue
// and trellis search engine. Depends on ccpc_pkg, ccpc_front, ccpc_queue, ccpc_back.
`timescale 1ns / 1ps
// Each item is one rate-1/n code; the result gives the gcd-is-one flag and
// the free distance. The front runs the gcd reduction over the generator pairs,
// and a catastrophic code then skips the trellis search and goes to the output
// register when the search engine is idle. A non-catastrophic code is searched
// one settled trellis state at a time, in the steps of two minimum-tree stages,
// expand and update. The
// two-entry queue lets the front classify the next code while a search runs.
// Configuration is taken at any time, through a port that is always ready.
module conv_code_property_check_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ccpc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ccpc_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data
);

    logic           f_valid, f_ready, q_valid, q_pop;
    ccpc_pkg::t_job f_job, q_job;

    ccpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    ccpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    ccpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_job),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/ccpc_front.sv
// Front end: configuration registers, item intake and the GF(2) gcd that
// classifies each code. Depends on ccpc_pkg.
`timescale 1ns / 1ps
module ccpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ccpc_pkg::t_in_item   i_in_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output ccpc_pkg::t_job       o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_GCD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_cfg_k;
    logic [2:0] r_cfg_n;
    ccpc_pkg::t_gens r_gens;
    logic [3:0] r_k, sat_k;
    logic [2:0] r_n, sat_n;
    logic [8:0] r_a, n_a, r_b, n_b;
    logic [2:0] r_idx, n_idx;
    logic       r_nc, n_nc;
    logic [3:0] deg_a, deg_b;
    logic       a_lower;

    function automatic logic [3:0] degree(input logic [8:0] v);
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) begin
            if (v[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != F_IDLE);
    assign o_job_valid = (r_state == F_PUSH);
    assign o_job       = '{gens: r_gens, k: r_k, n: r_n, nc: r_nc};

    always_comb begin
        priority if (r_cfg_k < ccpc_pkg::K_MIN) sat_k = ccpc_pkg::K_MIN;
        else if (r_cfg_k > ccpc_pkg::K_MAX)     sat_k = ccpc_pkg::K_MAX;
        else                                    sat_k = r_cfg_k;
        priority if (r_cfg_n < ccpc_pkg::N_MIN) sat_n = ccpc_pkg::N_MIN;
        else if (r_cfg_n > ccpc_pkg::N_MAX)     sat_n = ccpc_pkg::N_MAX;
        else                                    sat_n = r_cfg_n;
    end

    assign deg_a   = degree(r_a);
    assign deg_b   = degree(r_b);
    assign a_lower = (r_a == '0) || (deg_a < deg_b);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_idx   = r_idx;
        n_nc    = r_nc;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_a     = i_in_data.gen_0;
                    n_b     = i_in_data.gen_1;
                    n_idx   = 3'd2;
                    n_state = F_GCD;
                end
            end
            F_GCD: begin
                if (r_b != '0) begin
                    if (a_lower) begin
                        n_a = r_b;
                        n_b = r_a;
                    end else begin
                        n_a = r_a ^ 9'(r_b << (deg_a - deg_b));
                    end
                end else if (r_idx < r_n) begin
                    // fold in the next active generator
                    n_b   = r_gens[r_idx];
                    n_idx = r_idx + 3'd1;
                end else begin
                    n_nc    = (r_a == 9'd1);
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cfg_k <= ccpc_pkg::K_RESET;
            r_cfg_n <= ccpc_pkg::N_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && i_cfg_index == ccpc_pkg::CFG_CONSTRAINT_LENGTH) begin
                r_cfg_k <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == ccpc_pkg::CFG_GENERATOR_COUNT) begin
                r_cfg_n <= i_cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_idx <= n_idx;
        r_nc  <= n_nc;
        if (r_state == F_IDLE && i_in_valid) begin
            // generator j lands at index j
            r_gens <= {i_in_data.gen_4, i_in_data.gen_3, i_in_data.gen_2,
                       i_in_data.gen_1, i_in_data.gen_0};
            r_k    <= sat_k;
            r_n    <= sat_n;
        end
    end

endmodule

### rtl/core/ccpc_queue.sv
// Two-entry job queue between the classifier and the search engine.
// Depends on ccpc_pkg.
`timescale 1ns / 1ps
module ccpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  ccpc_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_pop,
    output ccpc_pkg::t_job  o_job
);

    ccpc_pkg::t_job r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/core/ccpc_back.sv
// Back end: shortest-path search over the trellis with a two-stage registered
// minimum tree, and the output register. Depends on ccpc_pkg.
`timescale 1ns / 1ps
module ccpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_pop,
    input  ccpc_pkg::t_job       i_job,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ccpc_pkg::t_out_item  o_out_data
);

    localparam int StW = ccpc_pkg::StW;
    localparam int WtW = ccpc_pkg::WtW;
    localparam int GS  = ccpc_pkg::GrpSize;
    localparam int NG  = ccpc_pkg::Groups;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_INIT = 3'd1;
    localparam logic [2:0] B_S1   = 3'd2;
    localparam logic [2:0] B_S2   = 3'd3;
    localparam logic [2:0] B_EXP  = 3'd4;
    localparam logic [2:0] B_UPD  = 3'd5;
    localparam logic [2:0] B_FIN  = 3'd6;

    typedef struct packed {
        logic           ok;
        logic [WtW-1:0] w;
        logic [StW-1:0] idx;
    } t_cand;

    typedef t_cand [GS-1:0] t_cand_row;

    logic [2:0]     r_state;
    ccpc_pkg::t_job r_job;
    logic           r_reached [ccpc_pkg::States];
    logic           r_settled [ccpc_pkg::States];
    logic [WtW-1:0] r_dist    [ccpc_pkg::States];
    t_cand          r_grp     [NG];
    t_cand          r_min;
    logic           r_ret_ok;
    logic [WtW-1:0] r_ret;
    logic [StW-1:0] r_v0, r_v1;
    logic [WtW-1:0] r_w0, r_w1;
    logic [5:0]     r_res;
    logic           r_out_valid;
    ccpc_pkg::t_out_item r_out;

    logic [StW-1:0] top_bit, seed;
    logic [2:0]     seed_w;
    logic           out_free;
    t_cand_row      grp_row;
    t_cand          grp_min [NG];
    t_cand          all_min;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        return (a.ok && (!b.ok || a.w <= b.w)) ? a : b;
    endfunction

    // lower index sits on the left, so ties go to the lower state
    function automatic t_cand min_row(input t_cand_row c);
        t_cand_row l;
        l = c;
        for (int s = GS / 2; s >= 1; s = s >> 1) begin
            for (int i = 0; i < GS / 2; i++) begin
                if (i < s) begin
                    l[i] = pick(l[2*i], l[2*i+1]);
                end
            end
        end
        return l[0];
    endfunction

    assign top_bit  = StW'(1) << (r_job.k - 4'd2);
    assign seed     = top_bit;
    assign seed_w   = ccpc_pkg::out_ones(r_job.gens, r_job.n, r_job.k, '0, 1'b1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_job_pop   = (r_state == B_IDLE) && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            for (int e = 0; e < GS; e++) begin
                grp_row[e].ok  = r_reached[g*GS+e] && !r_settled[g*GS+e];
                grp_row[e].w   = r_dist[g*GS+e];
                grp_row[e].idx = StW'(g*GS+e);
            end
            grp_min[g] = min_row(grp_row);
        end
    end

    always_comb begin
        t_cand_row row;
        for (int g = 0; g < NG; g++) begin
            row[g] = r_grp[g];
        end
        all_min = min_row(row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_ret_ok    <= 1'b0;
            for (int s = 0; s < ccpc_pkg::States; s++) begin
                r_reached[s] <= 1'b0;
                r_settled[s] <= 1'b0;
            end
        end else begin
            // drop the result once taken, unless a new one is loaded
            if (r_out_valid && !i_out_stall && r_state != B_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.nc ? B_INIT : B_FIN;
                    end
                end
                B_INIT: begin
                    r_ret_ok <= 1'b0;
                    for (int s = 0; s < ccpc_pkg::States; s++) begin
                        r_reached[s] <= (StW'(s) == seed);
                        r_settled[s] <= 1'b0;
                    end
                    r_state <= B_S1;
                end
                B_S1:  r_state <= B_S2;
                B_S2:  r_state <= B_EXP;
                B_EXP: begin
                    if (!r_min.ok) begin
                        r_state <= B_FIN;
                    end else begin
                        r_settled[r_min.idx] <= 1'b1;
                        r_state <= B_UPD;
                    end
                end
                B_UPD: begin
                    for (int s = 0; s < ccpc_pkg::States; s++) begin
                        if (!r_settled[s] && s != 0) begin
                            if (StW'(s) == r_v0 && (!r_reached[s] || r_w0 < r_dist[s])) begin
                                r_reached[s] <= 1'b1;
                            end
                            if (StW'(s) == r_v1 && (!r_reached[s] || r_w1 < r_dist[s])) begin
                                r_reached[s] <= 1'b1;
                            end
                        end
                    end
                    // only the zero-input branch can return to state zero
                    if (r_v0 == '0 && (!r_ret_ok || r_w0 < r_ret)) begin
                        r_ret_ok <= 1'b1;
                    end
                    r_state <= B_S1;
                end
                B_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid) begin
            r_job <= i_job;
            r_res <= '0;
        end
        if (r_state == B_INIT) begin
            for (int s = 0; s < ccpc_pkg::States; s++) begin
                r_dist[s] <= WtW'(seed_w);
            end
        end
        if (r_state == B_S1) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= grp_min[g];
            end
        end
        if (r_state == B_S2) begin
            r_min <= all_min;
        end
        if (r_state == B_EXP) begin
            r_v0 <= r_min.idx >> 1;
            r_v1 <= (r_min.idx >> 1) | top_bit;
            r_w0 <= r_min.w + WtW'(ccpc_pkg::out_ones(r_job.gens, r_job.n, r_job.k,
                                                      r_min.idx, 1'b0));
            r_w1 <= r_min.w + WtW'(ccpc_pkg::out_ones(r_job.gens, r_job.n, r_job.k,
                                                      r_min.idx, 1'b1));
            if (!r_min.ok && r_ret_ok) begin
                r_res <= (r_ret > WtW'(63)) ? 6'd63 : r_ret[5:0];
            end
        end
        if (r_state == B_UPD) begin
            for (int s = 0; s < ccpc_pkg::States; s++) begin
                if (!r_settled[s] && s != 0) begin
                    if (StW'(s) == r_v0 && (!r_reached[s] || r_w0 < r_dist[s])) begin
                        r_dist[s] <= r_w0;
                    end
                    if (StW'(s) == r_v1 && (!r_reached[s] || r_w1 < r_dist[s])) begin
                        r_dist[s] <= r_w1;
                    end
                end
            end
            if (r_v0 == '0 && (!r_ret_ok || r_w0 < r_ret)) begin
                r_ret <= r_w0;
            end
        end
        if (r_state == B_FIN && out_free) begin
            r_out.noncatastrophic <= r_job.nc;
            r_out.free_dist       <= r_res;
        end
    end

    a_dist_needs_nc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.free_dist != '0) |-> r_out.noncatastrophic)
        else $error("free distance reported for a catastrophic code");

    a_min_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EXP && r_min.ok) |-> (r_min.idx != '0))
        else $error("search selected state zero");

    a_fin_holds_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIN && r_out_valid && i_out_stall) |=> (r_state == B_FIN))
        else $error("result left while output register was held");

endmodule
